// ----- sv/vpo_pkg.sv -----
// shared constants, table generators and types for the volt-per-octave oscillator
package vpo_pkg;

  // default table and accumulator sizes
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int EXP_TABLE_BITS_DEF  = 8;
  localparam int PHASE_BITS_DEF      = 32;

  // field widths
  localparam int CV_W       = 16;
  localparam int OFS_W      = 15;
  localparam int HZ_W       = 24;
  localparam int SINE_W     = 16;
  localparam int SINE_MAG_W = 15;
  localparam int EXP_W      = 18;
  localparam int FREQ_W     = 21;
  localparam int FREQ_X_W   = 27;
  localparam int FREQ_SUM_W = 35;
  localparam int VOLT_FRAC_W = 12;
  localparam int OCT_W      = 4;
  localparam int PITCH_W    = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int PITCH_LIMIT    = 16384;
  localparam int BASE_HZ        = 440;
  localparam int FREQ_ROUND     = 2048;
  localparam int INC_ROUND_BITS = 8;
  localparam int INC_ROUND      = 128;
  localparam int FULL_SCALE     = 32767;

  localparam logic [HZ_W-1:0] HZ_STEP_RESET = 24'd97391;

  localparam logic [63:0] LN2_Q32     = 64'd2977044472;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_OFFSET = 2'd0,
    CFG_HZ_STEP      = 2'd1
  } cfg_idx_t;

  // 2^(i/2^tbits) in Q16, entry 2^tbits is exactly 2.0
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned i, input int unsigned tbits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    if (i >= (32'd1 << tbits)) begin
      res = 64'd2 << 16;
    end else begin
      y = (64'(i) * LN2_Q32) >> tbits;
      term = 64'd1 << 32;
      sum = term;
      term = ((term * y) >> 32) / 64'd1;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd2;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd3;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd4;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd5;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd6;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd7;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd8;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd9;  sum = sum + term;
      term = ((term * y) >> 32) / 64'd10; sum = sum + term;
      term = ((term * y) >> 32) / 64'd11; sum = sum + term;
      term = ((term * y) >> 32) / 64'd12; sum = sum + term;
      term = ((term * y) >> 32) / 64'd13; sum = sum + term;
      term = ((term * y) >> 32) / 64'd14; sum = sum + term;
      term = ((term * y) >> 32) / 64'd15; sum = sum + term;
      term = ((term * y) >> 32) / 64'd16; sum = sum + term;
      term = ((term * y) >> 32) / 64'd17; sum = sum + term;
      term = ((term * y) >> 32) / 64'd18; sum = sum + term;
      term = ((term * y) >> 32) / 64'd19; sum = sum + term;
      term = ((term * y) >> 32) / 64'd20; sum = sum + term;
      res = (sum + (64'd1 << 15)) >> 16;
    end
    return res[EXP_W-1:0];
  endfunction

  // quarter-wave sine magnitude, entry 2^sbits is the peak
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned j,
                                                       input int unsigned sbits);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    theta = (64'(j) * HALF_PI_Q30) >> sbits;
    theta2 = (theta * theta) >> 30;
    term = theta;
    sum = $signed(theta);
    term = ((term * theta2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * theta2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * theta2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * theta2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd272; sum = sum + $signed(term);
    term = ((term * theta2) >> 30) / 64'd342; sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd420; sum = sum + $signed(term);
    term = ((term * theta2) >> 30) / 64'd506; sum = sum - $signed(term);
    term = ((term * theta2) >> 30) / 64'd600; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

// ----- sv/volt_per_octave_sine_oscillator.sv -----
// Volt-per-octave sine oscillator. Each transfer on the in_ channel is one audio sample tick
// carrying a Q4.12 pitch voltage; it is added to the pitch_offset register, clamped to +/-4 V
// and turned into 440*2^pitch Hz (Q.8) through an interpolated exp2 table. That frequency is
// multiplied by hz_step one bit per cycle and the product bits are added serially into the
// PHASE_BITS oscillator phase, while the 1 Hz blink phase advances by hz_step through a second
// serial adder. The new phase addresses a quarter-wave sine table (32767 is +5 V) and
// blink_on is high for the first half of the blink period. Each item passes in turn through
// the transfer and the exp table path, the bit-serial multiply and phase adds, and the sine
// lookup and output load. A new item is taken as soon as the previous result sits in the
// output register, even while it is stalled. Configuration writes are taken in any cycle and
// belong in idle periods.
module volt_per_octave_sine_oscillator #(
  parameter int SINE_TABLE_BITS = vpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int EXP_TABLE_BITS  = vpo_pkg::EXP_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = vpo_pkg::PHASE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vpo_pkg::CV_W-1:0]       in_pitch_cv,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vpo_pkg::SINE_W-1:0]     out_sine_out,
  output logic                                  out_blink_on,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vpo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vpo_pkg::CFG_DATA_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_PITCH,
    T_SERIAL,
    T_SINE,
    T_HOLD
  } top_state_t;

  top_state_t state_r;

  logic signed [vpo_pkg::OFS_W-1:0] pitch_offset_r;
  logic [vpo_pkg::HZ_W-1:0]         hz_step_r;

  logic                              pitch_start;
  logic                              pitch_done;
  logic [vpo_pkg::FREQ_W-1:0]        freq;
  logic                              serial_start;
  logic                              serial_done;
  logic [PHASE_BITS-1:0]             osc_phase;
  logic                              blink_msb;
  logic                              sine_start;
  logic                              sine_done;
  logic signed [vpo_pkg::SINE_W-1:0] sine;

  logic                              out_valid_r;
  logic signed [vpo_pkg::SINE_W-1:0] out_sine_r;
  logic                              out_blink_r;
  logic                              out_free;
  logic                              load;

  assign in_stall     = (state_r != T_IDLE);
  assign pitch_start  = in_valid && (state_r == T_IDLE);
  assign serial_start = pitch_done && (state_r == T_PITCH);
  assign sine_start   = serial_done && (state_r == T_SERIAL);
  assign out_free     = !out_valid_r || !out_stall;
  assign load         = out_free && (((state_r == T_SINE) && sine_done) || (state_r == T_HOLD));

  vpo_pitch #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_pitch (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (pitch_start),
    .pitch_cv     (in_pitch_cv),
    .pitch_offset (pitch_offset_r),
    .done         (pitch_done),
    .freq         (freq)
  );

  vpo_serial #(
    .PHASE_BITS (PHASE_BITS)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (serial_start),
    .freq      (freq),
    .hz_step   (hz_step_r),
    .done      (serial_done),
    .osc_phase (osc_phase),
    .blink_msb (blink_msb)
  );

  vpo_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sine_start),
    .phase_top (osc_phase[PHASE_BITS-1 -: SINE_TABLE_BITS + 2]),
    .done      (sine_done),
    .sine      (sine)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_offset_r <= '0;
      hz_step_r      <= vpo_pkg::HZ_STEP_RESET;
    end else if (cfg_valid) begin
      unique case (vpo_pkg::cfg_idx_t'(cfg_index))
        vpo_pkg::CFG_PITCH_OFFSET: pitch_offset_r <= $signed(cfg_data[vpo_pkg::OFS_W-1:0]);
        vpo_pkg::CFG_HZ_STEP:      hz_step_r      <= cfg_data[vpo_pkg::HZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r  <= 1'b1;
        out_sine_r   <= sine;
        out_blink_r  <= !blink_msb;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_valid) begin
            state_r <= T_PITCH;
          end
        end
        T_PITCH: begin
          if (pitch_done) begin
            state_r <= T_SERIAL;
          end
        end
        T_SERIAL: begin
          if (serial_done) begin
            state_r <= T_SINE;
          end
        end
        T_SINE: begin
          if (sine_done) begin
            state_r <= out_free ? T_IDLE : T_HOLD;
          end
        end
        T_HOLD: begin
          if (out_free) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sine_out = out_sine_r;
  assign out_blink_on = out_blink_r;
  assign cfg_ready    = 1'b1;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not make the block busy");

  a_pitch_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_done |-> (state_r == T_PITCH))
    else $error("frequency finished outside the pitch step");

  a_serial_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    serial_done |-> (state_r == T_SERIAL))
    else $error("phase update finished outside the serial step");

  a_sine_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sine_done |-> (state_r == T_SINE))
    else $error("sine lookup finished outside the sine step");

  a_load_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((state_r == T_HOLD) || sine_done))
    else $error("output loaded without a finished lookup");

endmodule

// ----- sv/vpo_pitch.sv -----
// pitch sum, clamp, exp2 table interpolation and scaling to a Q.8 frequency
module vpo_pitch #(
  parameter int EXP_TABLE_BITS = vpo_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [vpo_pkg::CV_W-1:0]   pitch_cv,
  input  logic signed [vpo_pkg::OFS_W-1:0]  pitch_offset,
  output logic                              done,
  output logic [vpo_pkg::FREQ_W-1:0]        freq
);

  localparam int EXP_DEPTH = (1 << EXP_TABLE_BITS) + 1;
  localparam int ADDR_W    = EXP_TABLE_BITS + 1;
  localparam int EXP_SHIFT = vpo_pkg::VOLT_FRAC_W - EXP_TABLE_BITS;
  localparam int REM_W     = (EXP_SHIFT > 0) ? EXP_SHIFT : 1;
  localparam int PROD_W    = vpo_pkg::EXP_W + REM_W;

  typedef enum logic [2:0] {
    P_IDLE,
    P_RD_A,
    P_RD_B,
    P_INTERP,
    P_SCALE,
    P_ROUND
  } pitch_state_t;

  pitch_state_t state_r;

  logic [vpo_pkg::EXP_W-1:0] exp_rom [EXP_DEPTH];

  for (genvar i = 0; i < EXP_DEPTH; i++) begin : g_exp_rom
    assign exp_rom[i] = vpo_pkg::exp_entry(i, EXP_TABLE_BITS);
  end

  logic signed [vpo_pkg::PITCH_W-1:0] pitch_sum;
  logic signed [vpo_pkg::PITCH_W-1:0] pitch_clamped;
  logic [15:0]                        pitch_u;
  logic [vpo_pkg::VOLT_FRAC_W-1:0]    frac;
  logic [REM_W-1:0]                   rem;

  logic [vpo_pkg::OCT_W-1:0]    oct_r;
  logic [EXP_TABLE_BITS-1:0]    idx_r;
  logic [REM_W-1:0]             rem_r;
  logic [ADDR_W-1:0]            rom_addr;
  logic [vpo_pkg::EXP_W-1:0]    rom_q_r;
  logic [vpo_pkg::EXP_W-1:0]    a_r;
  logic [vpo_pkg::EXP_W-1:0]    e_r;
  logic [vpo_pkg::EXP_W-1:0]    e_nxt;
  logic [PROD_W-1:0]            prod;
  logic [vpo_pkg::FREQ_X_W-1:0] x_r;
  logic [vpo_pkg::FREQ_SUM_W-1:0] shl;
  logic [vpo_pkg::FREQ_SUM_W-1:0] rounded;
  logic [vpo_pkg::FREQ_W-1:0]   freq_r;
  logic                         done_r;

  always_comb begin
    pitch_sum = vpo_pkg::PITCH_W'(pitch_cv) + vpo_pkg::PITCH_W'(pitch_offset);
    if (pitch_sum > vpo_pkg::PITCH_W'(vpo_pkg::PITCH_LIMIT)) begin
      pitch_clamped = vpo_pkg::PITCH_W'(vpo_pkg::PITCH_LIMIT);
    end else if (pitch_sum < -vpo_pkg::PITCH_W'(vpo_pkg::PITCH_LIMIT)) begin
      pitch_clamped = -vpo_pkg::PITCH_W'(vpo_pkg::PITCH_LIMIT);
    end else begin
      pitch_clamped = pitch_sum;
    end
    pitch_u = 16'(pitch_clamped + vpo_pkg::PITCH_W'(vpo_pkg::PITCH_LIMIT));
    frac = pitch_u[vpo_pkg::VOLT_FRAC_W-1:0];
  end

  if (EXP_SHIFT > 0) begin : g_rem
    assign rem = frac[REM_W-1:0];
  end else begin : g_no_rem
    assign rem = '0;
  end

  // first read fetches the lower entry, second the upper one
  assign rom_addr = (state_r == P_RD_A) ? {1'b0, idx_r} : ({1'b0, idx_r} + ADDR_W'(1));

  assign prod    = PROD_W'(rom_q_r - a_r) * PROD_W'(rem_r);
  assign e_nxt   = a_r + vpo_pkg::EXP_W'(prod >> EXP_SHIFT);
  assign shl     = vpo_pkg::FREQ_SUM_W'(x_r) << oct_r;
  assign rounded = shl + vpo_pkg::FREQ_SUM_W'(vpo_pkg::FREQ_ROUND);

  always_ff @(posedge clk) begin
    rom_q_r <= exp_rom[rom_addr];
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == P_ROUND);
      unique case (state_r)
        P_IDLE: begin
          if (start) begin
            oct_r   <= pitch_u[15:vpo_pkg::VOLT_FRAC_W];
            idx_r   <= frac[vpo_pkg::VOLT_FRAC_W-1 -: EXP_TABLE_BITS];
            rem_r   <= rem;
            state_r <= P_RD_A;
          end
        end
        P_RD_A: begin
          state_r <= P_RD_B;
        end
        P_RD_B: begin
          a_r     <= rom_q_r;
          state_r <= P_INTERP;
        end
        P_INTERP: begin
          e_r     <= e_nxt;
          state_r <= P_SCALE;
        end
        P_SCALE: begin
          x_r     <= vpo_pkg::FREQ_X_W'(e_r) * vpo_pkg::FREQ_X_W'(vpo_pkg::BASE_HZ);
          state_r <= P_ROUND;
        end
        P_ROUND: begin
          freq_r  <= rounded[vpo_pkg::VOLT_FRAC_W +: vpo_pkg::FREQ_W];
          state_r <= P_IDLE;
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign freq = freq_r;

endmodule

// ----- sv/vpo_serial.sv -----
// bit-serial frequency by hz_step multiply feeding serial phase and blink adders
module vpo_serial #(
  parameter int PHASE_BITS = vpo_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vpo_pkg::FREQ_W-1:0]  freq,
  input  logic [vpo_pkg::HZ_W-1:0]    hz_step,
  output logic                        done,
  output logic [PHASE_BITS-1:0]       osc_phase,
  output logic                        blink_msb
);

  localparam int SER_LEN = PHASE_BITS + vpo_pkg::INC_ROUND_BITS;
  localparam int CNT_W   = $clog2(SER_LEN);

  logic [CNT_W-1:0]              cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [PHASE_BITS-1:0]         osc_r;
  logic [PHASE_BITS-1:0]         blink_r;
  logic                          osc_c_r;
  logic                          blink_c_r;
  logic [vpo_pkg::HZ_W-1:0]      hz_sr_r;
  logic [vpo_pkg::FREQ_W-1:0]    mcand_r;
  logic [vpo_pkg::FREQ_W-1:0]    acc_r;

  logic [vpo_pkg::FREQ_W:0]      psum;
  logic                          pbit;
  logic                          osc_bit;
  logic                          osc_cy;
  logic                          blink_bit;
  logic                          blink_cy;
  logic                          osc_act;
  logic                          blink_act;
  logic                          last;

  always_comb begin
    // product bits leave lsb first, rounding constant preloaded in the accumulator
    psum = {1'b0, acc_r} + (hz_sr_r[0] ? {1'b0, mcand_r} : '0);
    pbit = psum[0];
    osc_bit   = osc_r[0] ^ pbit ^ osc_c_r;
    osc_cy    = (osc_r[0] & pbit) | (osc_c_r & (osc_r[0] ^ pbit));
    blink_bit = blink_r[0] ^ hz_sr_r[0] ^ blink_c_r;
    blink_cy  = (blink_r[0] & hz_sr_r[0]) | (blink_c_r & (blink_r[0] ^ hz_sr_r[0]));
    osc_act   = cnt_r >= CNT_W'(vpo_pkg::INC_ROUND_BITS);
    blink_act = cnt_r < CNT_W'(PHASE_BITS);
    last      = cnt_r == CNT_W'(SER_LEN - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
      osc_r     <= '0;
      blink_r   <= '0;
      osc_c_r   <= 1'b0;
      blink_c_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        osc_c_r   <= 1'b0;
        blink_c_r <= 1'b0;
        hz_sr_r   <= hz_step;
        mcand_r   <= freq;
        acc_r     <= vpo_pkg::FREQ_W'(vpo_pkg::INC_ROUND);
      end else if (busy_r) begin
        hz_sr_r <= hz_sr_r >> 1;
        acc_r   <= psum[vpo_pkg::FREQ_W:1];
        cnt_r   <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
        if (osc_act) begin
          osc_r   <= {osc_bit, osc_r[PHASE_BITS-1:1]};
          osc_c_r <= osc_cy;
        end
        if (blink_act) begin
          blink_r   <= {blink_bit, blink_r[PHASE_BITS-1:1]};
          blink_c_r <= blink_cy;
        end
      end
    end
  end

  assign done      = done_r;
  assign osc_phase = osc_r;
  assign blink_msb = blink_r[PHASE_BITS-1];

endmodule

// ----- sv/vpo_sine.sv -----
// quarter-wave sine table lookup with quadrant mirror and sign
module vpo_sine #(
  parameter int SINE_TABLE_BITS = vpo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [SINE_TABLE_BITS+1:0]         phase_top,
  output logic                               done,
  output logic signed [vpo_pkg::SINE_W-1:0]  sine
);

  localparam int QUARTER = 1 << SINE_TABLE_BITS;
  localparam int DEPTH   = QUARTER + 1;
  localparam int ADDR_W  = SINE_TABLE_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SIGN
  } sine_state_t;

  sine_state_t state_r;

  logic [vpo_pkg::SINE_MAG_W-1:0] sine_rom [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_sine_rom
    assign sine_rom[j] = vpo_pkg::sine_entry(j, SINE_TABLE_BITS);
  end

  logic [ADDR_W-1:0]               addr;
  logic [ADDR_W-1:0]               addr_r;
  logic                            neg_r;
  logic [vpo_pkg::SINE_MAG_W-1:0]  rom_q_r;
  logic signed [vpo_pkg::SINE_W-1:0] mag;
  logic signed [vpo_pkg::SINE_W-1:0] sine_r;
  logic                            done_r;

  // odd quadrants run the table backwards
  assign addr = phase_top[SINE_TABLE_BITS] ?
                (ADDR_W'(QUARTER) - {1'b0, phase_top[SINE_TABLE_BITS-1:0]}) :
                {1'b0, phase_top[SINE_TABLE_BITS-1:0]};

  assign mag = $signed({1'b0, rom_q_r});

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[addr_r];
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_SIGN);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            addr_r  <= addr;
            neg_r   <= phase_top[SINE_TABLE_BITS+1];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          sine_r  <= neg_r ? -mag : mag;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign sine = sine_r;

endmodule

// ----- bench/tb_volt_per_octave_sine_oscillator.sv -----
// self-checking testbench for the volt-per-octave sine oscillator with blink flag
module tb_volt_per_octave_sine_oscillator;
  timeunit 1ns;
  timeprecision 1ps;

  import vpo_pkg::*;

  localparam int SB = SINE_TABLE_BITS_DEF;
  localparam int EB = EXP_TABLE_BITS_DEF;
  localparam int PH = PHASE_BITS_DEF;
  localparam int TICK_CYCLES = PH + 19;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [SINE_W-1:0] sine;
    logic                     blink;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CV_W-1:0] in_pitch_cv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SINE_W-1:0] out_sine_out;
  logic out_blink_on;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  volt_per_octave_sine_oscillator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pitch_cv  (in_pitch_cv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sine_out (out_sine_out),
    .out_blink_on (out_blink_on),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // oscillator model state and register copies
  logic signed [OFS_W-1:0] knob_ofs = '0;
  logic [HZ_W-1:0] step_1hz = HZ_STEP_RESET;
  logic [PH-1:0] osc_acc = '0;
  logic [PH-1:0] blink_acc = '0;
  logic [63:0] exp2_tab [0:(1 << EB)];
  int sine_tab [0:(1 << SB)];

  tick_result_t samples_due[$];
  int errors = 0;
  int ticks_sent = 0;
  int samples_checked = 0;
  int reg_writes = 0;
  int clamped_hi = 0;
  int clamped_lo = 0;
  int blink_edges = 0;
  logic last_blink = 1'b1;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;
  int calm_left = 0;

  // 2^(i/N) in Q16 by series expansion in Q32
  function automatic logic [63:0] two_pow_q16(input int unsigned i);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    if (i >= (1 << EB)) return 64'd2 << 16;
    y = (64'(i) * LN2_Q32) >> EB;
    term = 64'd1 << 32;
    acc = term;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      acc = acc + term;
    end
    return (acc + (64'd1 << 15)) >> 16;
  endfunction

  // quarter-wave magnitude scaled to full scale, series in Q30
  function automatic int quarter_sine(input int unsigned j);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic signed [63:0] v;
    theta = (64'(j) * HALF_PI_Q30) >> SB;
    theta2 = (theta * theta) >> 30;
    term = theta;
    acc = $signed(theta);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * theta2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    v = (acc * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return int'(v);
  endfunction

  // advance both accumulators by one sample tick and return the expected sample
  function automatic tick_result_t oscillate(input logic signed [CV_W-1:0] cv);
    tick_result_t r;
    int pitch;
    int unsigned u;
    int unsigned octave;
    int unsigned frac;
    int unsigned idx;
    int unsigned rem;
    logic [63:0] e;
    logic [63:0] freq;
    logic [63:0] inc;
    logic [SB+1:0] top;
    int mag;
    pitch = int'(cv) + int'(knob_ofs);
    if (pitch > PITCH_LIMIT) begin
      pitch = PITCH_LIMIT;
      clamped_hi++;
    end
    if (pitch < -PITCH_LIMIT) begin
      pitch = -PITCH_LIMIT;
      clamped_lo++;
    end
    u = pitch + PITCH_LIMIT;
    octave = u >> VOLT_FRAC_W;
    frac = u & ((1 << VOLT_FRAC_W) - 1);
    idx = frac >> (VOLT_FRAC_W - EB);
    rem = frac & ((1 << (VOLT_FRAC_W - EB)) - 1);
    e = exp2_tab[idx] + (((exp2_tab[idx + 1] - exp2_tab[idx]) * 64'(rem)) >> (VOLT_FRAC_W - EB));
    freq = ((64'(BASE_HZ) * e << octave) + FREQ_ROUND) >> VOLT_FRAC_W;
    inc = (freq * 64'(step_1hz) + INC_ROUND) >> INC_ROUND_BITS;
    osc_acc = osc_acc + inc[PH-1:0];
    top = osc_acc[PH-1 -: SB+2];
    // odd quadrants run the table backwards, the upper half is negated
    if (top[SB]) mag = sine_tab[(1 << SB) - int'(top[SB-1:0])];
    else mag = sine_tab[top[SB-1:0]];
    r.sine = top[SB+1] ? SINE_W'(-mag) : SINE_W'(mag);
    blink_acc = blink_acc + PH'(step_1hz);
    r.blink = ~blink_acc[PH-1];
    return r;
  endfunction

  task automatic send_tick(input logic signed [CV_W-1:0] cv);
    tick_result_t r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch_cv <= cv;
    do @(posedge clk); while (in_stall);
    r = oscillate(cv);
    samples_due.push_back(r);
    ticks_sent++;
  endtask

  // lower valid and wait until every sample in flight has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PITCH_OFFSET) knob_ofs = data[OFS_W-1:0];
    else if (idx == CFG_HZ_STEP) step_1hz = data[HZ_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic signed [CV_W-1:0] random_cv();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5, 6: v = int'($urandom_range(0, 40960)) - 20480;
      7: v = ($urandom_range(0, 1) ? PITCH_LIMIT : -PITCH_LIMIT) - int'(knob_ofs)
             + int'($urandom_range(0, 4)) - 2;
      8: v = int'(in_pitch_cv) + int'($urandom_range(0, 64)) - 32;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CV_W'(v);
  endfunction

  task automatic test_reset_state();
    int cvs[] = '{0, 32767, -32768, 4096, -4096, 16384, -16384, 1, -1};
    foreach (cvs[i]) send_tick(CV_W'(cvs[i]));
    settle();
  endtask

  task automatic test_offset_extremes();
    // last two leave the legal knob range: the clamp still bounds the pitch
    logic [CFG_DATA_W-1:0] ofs[] = '{24'(12288), 24'(-12288), 24'h003FFF, 24'hFFC000};
    foreach (ofs[i]) begin
      write_reg(CFG_PITCH_OFFSET, ofs[i]);
      send_tick('0);
      send_tick(i % 2 ? CV_W'(32767) : CV_W'(-32768));
      settle();
    end
  endtask

  task automatic test_step_extremes();
    // zero step freezes both accumulators, full step gives the largest phase increments
    logic [CFG_DATA_W-1:0] steps[] = '{24'd0, 24'd1, 24'hFFFFFF};
    write_reg(CFG_PITCH_OFFSET, '0);
    foreach (steps[i]) begin
      write_reg(CFG_HZ_STEP, steps[i]);
      send_tick(CV_W'(5000));
      send_tick(CV_W'(-5000));
      settle();
    end
  endtask

  task automatic test_unknown_index();
    write_reg(CFG_SPARE_2, 24'hFFFFFF);
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
    send_tick(CV_W'(2048));
    send_tick(CV_W'(-2048));
    settle();
  endtask

  task automatic test_random_phases();
    int v;
    for (int p = 0; p < 9; p++) begin
      settle();
      case ($urandom_range(0, 3))
        0: v = int'($urandom);
        1: v = $urandom_range(0, 1) ? 12288 : -12288;
        default: v = int'($urandom_range(0, 24576)) - 12288;
      endcase
      write_reg(CFG_PITCH_OFFSET, CFG_DATA_W'(v));
      case ($urandom_range(0, 3))
        0: v = $urandom_range(1, 24'hFFFFFF);
        1: v = $urandom_range(89478, 536871);
        2: v = $urandom_range(0, 1) ? 24'hFFFFFF : 1;
        default: v = $urandom_range(4000000, 24'hFFFFFF);
      endcase
      write_reg(CFG_HZ_STEP, CFG_DATA_W'(v));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat (110) send_tick(random_cv());
    end
    settle();
  endtask

  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_PITCH_OFFSET, CFG_DATA_W'(int'($urandom_range(0, 24576)) - 12288));
    write_reg(CFG_HZ_STEP, CFG_DATA_W'($urandom_range(1000000, 24'hFFFFFF)));
    repeat (60) send_tick(random_cv());
  endtask

  // receiver back-pressure: short bursts, with calm stretches in between
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 59) == 0) begin
      calm_left = $urandom_range(40, 300);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  tick_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (samples_due.size() == 0) begin
        $display("%0t: sample with nothing pending: sine %0d blink %0b",
                 $time, out_sine_out, out_blink_on);
        errors++;
      end else begin
        want = samples_due.pop_front();
        if (out_sine_out !== want.sine) begin
          $display("%0t: sine_out expected %0d actual %0d", $time, want.sine, out_sine_out);
          errors++;
        end
        if (out_blink_on !== want.blink) begin
          $display("%0t: blink_on expected %0b actual %0b", $time, want.blink, out_blink_on);
          errors++;
        end
        if (out_blink_on !== last_blink) blink_edges++;
        last_blink = out_blink_on;
        samples_checked++;
      end
    end
  end

  initial begin
    int waited;
    for (int i = 0; i <= (1 << EB); i++) exp2_tab[i] = two_pow_q16(i);
    for (int j = 0; j <= (1 << SB); j++) sine_tab[j] = quarter_sine(j);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_offset_extremes();
    test_step_extremes();
    test_unknown_index();
    test_random_phases();
    test_quiet_tail();
    in_valid <= 1'b0;
    waited = 0;
    while (samples_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TICK_CYCLES + 10) @(posedge clk);
    if (samples_due.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, samples_due.size());
      errors++;
    end
    $display("covered %0d ticks, %0d samples checked, %0d register writes",
             ticks_sent, samples_checked, reg_writes);
    $display("pitch clamped high %0d / low %0d times, blink flag changed %0d times",
             clamped_hi, clamped_lo, blink_edges);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
